[hdl/nst_pkg.sv]
`default_nettype none
package nst_pkg;

  localparam int SIZE_W          = 8;
  localparam int IDENT_W         = 32;
  localparam int MAX_ENTRIES_DEF = 16;

  // Command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic [SIZE_W-1:0]  size;
    logic [IDENT_W-1:0] ident;
  } entry_t;

  typedef struct packed {
    logic               have;
    logic [SIZE_W-1:0]  size;
    logic [IDENT_W-1:0] ident;
  } best_t;

endpackage
`default_nettype wire

[hdl/nearest_size_table_lookup.sv]
`default_nettype none
// Nearest-size lookup over a table of up to MAX_ENTRIES (size, ident) pairs held in a
// synchronous RAM with one write and one read port. Commands: clear, insert (dropped
// with status full when the table is full), and query, which returns the entry closest
// to query_size, the larger size on a tie and the earlier entry on equal size, or status
// no-entry when empty.
// One command is in flight at a time. Clear, insert, an unused code and a query on an
// empty table put their result in the output register in the cycle after acceptance. A
// query on a table of N entries reads one entry per cycle through the RAM's registered
// read port; the last entry read is then compared in the wait state, and the finish
// state loads the result into the output register. A new command is taken once the
// output register is empty or being drained in the same cycle. Writes happen only at
// acceptance and reads only during a scan, so the RAM never sees both on one entry.
module nearest_size_table_lookup #(
  parameter int MAX_ENTRIES = nst_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          command,
  input  wire logic [nst_pkg::SIZE_W-1:0]          entry_size,
  input  wire logic signed [nst_pkg::IDENT_W-1:0]  entry_ident,
  input  wire logic [nst_pkg::SIZE_W-1:0]          query_size,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [nst_pkg::IDENT_W-1:0]       found_ident,
  output logic [nst_pkg::SIZE_W-1:0]               found_size,
  output logic [1:0]                               status
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_WAIT   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]                 state;
  logic [CW-1:0]              count;
  logic [AW-1:0]              scan_addr;
  logic [nst_pkg::SIZE_W-1:0] qsize;
  logic                       data_valid;

  logic                       accept;
  logic                       full;
  logic                       scan_last;
  logic                       wr_en;
  nst_pkg::entry_t            wr_data;
  nst_pkg::entry_t            rd_data;
  nst_pkg::best_t             best;
  logic                       start;

  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign full      = (count == CW'(MAX_ENTRIES));
  assign scan_last = (CW'(scan_addr) == CW'(count - CW'(1)));
  assign wr_en     = accept && (command == nst_pkg::CMD_INSERT) && !full;
  assign start     = accept && (command == nst_pkg::CMD_QUERY);

  always_comb begin
    wr_data.size  = entry_size;
    wr_data.ident = entry_ident;
  end

  nst_table #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (state == S_SCAN),
    .rd_addr (scan_addr),
    .rd_data (rd_data)
  );

  nst_best u_best (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .sample (data_valid),
    .qsize  (qsize),
    .cand   (rd_data),
    .best   (best)
  );

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      data_valid <= 1'b0;
    end else begin
      data_valid <= (state == S_SCAN);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (command == nst_pkg::CMD_CLEAR) begin
              count <= '0;
            end else if (wr_en) begin
              count <= count + CW'(1);
            end else if (start && (count != '0)) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_last) begin
            state <= S_WAIT;
          end
        end
        S_WAIT:   state <= S_FINISH;
        S_FINISH: state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      scan_addr <= '0;
      qsize     <= query_size;
    end else if (state == S_SCAN) begin
      scan_addr <= scan_addr + AW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((accept && !(start && (count != '0))) || (state == S_FINISH)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH) begin
      if (best.have) begin
        found_ident <= $signed(best.ident);
        found_size  <= best.size;
        status      <= nst_pkg::ST_OK;
      end else begin
        found_ident <= '0;
        found_size  <= '0;
        status      <= nst_pkg::ST_NONE;
      end
    end else if (accept) begin
      found_ident <= '0;
      found_size  <= '0;
      if ((command == nst_pkg::CMD_INSERT) && full) begin
        status <= nst_pkg::ST_FULL;
      end else if (start) begin
        status <= nst_pkg::ST_NONE;
      end else begin
        status <= nst_pkg::ST_OK;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES))
    else $error("entry count beyond table depth");

  a_finish_has_best: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) |-> best.have)
    else $error("scan finished without a candidate");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && (command == nst_pkg::CMD_INSERT) && full)
      |=> (out_valid && (status == nst_pkg::ST_FULL) && $stable(count)))
    else $error("insert into full table not reported");

  a_query_scan: assert property (@(posedge clk) disable iff (rst)
    (start && (count != '0)) |=> (state == S_SCAN) && !out_valid)
    else $error("query on nonempty table did not start a scan");
`endif

endmodule
`default_nettype wire

[hdl/nst_table.sv]
`default_nettype none
module nst_table #(
  parameter int DEPTH = nst_pkg::MAX_ENTRIES_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic           clk,
  input  wire logic           wr_en,
  input  wire logic [AW-1:0]  wr_addr,
  input  wire nst_pkg::entry_t wr_data,
  input  wire logic           rd_en,
  input  wire logic [AW-1:0]  rd_addr,
  output nst_pkg::entry_t     rd_data
);

  nst_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[hdl/nst_best.sv]
`default_nettype none
module nst_best (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic                       sample,
  input  wire logic [nst_pkg::SIZE_W-1:0] qsize,
  input  wire nst_pkg::entry_t            cand,
  output nst_pkg::best_t                  best
);

  logic [nst_pkg::SIZE_W-1:0] delta;
  logic [nst_pkg::SIZE_W-1:0] cand_delta;
  logic                       take;

  always_comb begin
    cand_delta = (cand.size > qsize) ? (cand.size - qsize) : (qsize - cand.size);
    // on equal distance keep the larger size; on equal size keep the earlier entry
    take = !best.have || (cand_delta < delta) ||
           ((cand_delta == delta) && (cand.size > best.size));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best.have <= 1'b0;
    end else if (start) begin
      best.have <= 1'b0;
    end else if (sample && take) begin
      best.have  <= 1'b1;
      best.size  <= cand.size;
      best.ident <= cand.ident;
      delta      <= cand_delta;
    end
  end

endmodule
`default_nettype wire
